[rtl/cpol_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpol_pkg
// Shared constants and elaboration-time helpers for the rectangular to polar
// CORDIC core: angle formats, the arctangent table and the inverse gain.
// ----------------------------------------------------------------------------
package cpol_pkg;

    // Fraction bits added to x and y ahead of the micro-rotations
    localparam int GUARD_BITS = 8;
    // Angle accumulator: signed, units of 2^-23 degree
    localparam int Z_W        = 34;
    localparam int TABLE_LEN  = 32;
    // Direction output width (Q9.7 degrees)
    localparam int DIR_W      = 16;

    localparam logic signed [Z_W-1:0] DEG180_Q23 = 34'sd1509949440;
    localparam logic signed [Z_W-1:0] DEG360_Q23 = 34'sd3019898880;
    localparam logic [DIR_W:0]        DEG360_Q7  = 17'd46080;

    // atan(2^-i) in degrees times 2^23, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_Q23 [0:TABLE_LEN-1] = '{
        34'sd377487360, 34'sd222843801, 34'sd117744544, 34'sd59768969,
        34'sd30000467,  34'sd15014858,  34'sd7509261,   34'sd3754860,
        34'sd1877459,   34'sd938733,    34'sd469367,    34'sd234683,
        34'sd117342,    34'sd58671,     34'sd29335,     34'sd14668,
        34'sd7334,      34'sd3667,      34'sd1833,      34'sd917,
        34'sd458,       34'sd229,       34'sd115,       34'sd57,
        34'sd29,        34'sd14,        34'sd7,         34'sd4,
        34'sd2,         34'sd1,         34'sd0,         34'sd0
    };

    // Inverse CORDIC gain in Q32 for a given iteration count. Evaluated at
    // elaboration only: square root and long division done bit by bit.
    function automatic logic [31:0] inv_gain_q32(input int iters);
        logic [63:0] g2;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        logic [63:0] g;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        int i;
        g2 = 64'd1 << 30;
        for (i = 0; i < iters && i < TABLE_LEN; i++) begin
            g2 = g2 + (g2 >> (2 * i));
        end
        v     = g2 << 30;
        res   = 64'd0;
        bit_m = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (bit_m > v) begin
                bit_m = bit_m >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (bit_m != 64'd0) begin
                if (v >= res + bit_m) begin
                    v   = v - (res + bit_m);
                    res = (res >> 1) + bit_m;
                end else begin
                    res = res >> 1;
                end
                bit_m = bit_m >> 2;
            end
        end
        g = (res == 64'd0) ? 64'd1 : res;
        num = (64'd1 << 62) + (g >> 1);
        rem = 64'd0;
        quo = 64'd0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= g) begin
                rem    = rem - g;
                quo[i] = 1'b1;
            end
        end
        return quo[31:0];
    endfunction

endpackage
`default_nettype wire

[rtl/cpol_prerot.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpol_prerot
// Input stage: scale x and y by the guard bits, fold the left half plane
// onto the right one and seed the angle accumulator.
// ----------------------------------------------------------------------------
module cpol_prerot #(
    parameter int DATA_WIDTH = 16,
    parameter int XW         = 27
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [DATA_WIDTH-1:0]  x_in,
    input  wire logic signed [DATA_WIDTH-1:0]  y_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [XW-1:0]               x_out,
    output logic signed [XW-1:0]               y_out,
    output logic signed [cpol_pkg::Z_W-1:0]    z_out,
    output logic                               zero_out
);
    import cpol_pkg::*;

    localparam int EXT_W = XW - DATA_WIDTH - GUARD_BITS;

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic                 zero_reg, zero_next;
    logic signed [XW-1:0] x_sh, y_sh;
    logic                 advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        x_sh = {{EXT_W{x_in[DATA_WIDTH-1]}}, x_in, {GUARD_BITS{1'b0}}};
        y_sh = {{EXT_W{y_in[DATA_WIDTH-1]}}, y_in, {GUARD_BITS{1'b0}}};
        zero_next = (x_in == '0) && (y_in == '0);
        if (x_in[DATA_WIDTH-1]) begin
            x_next = -x_sh;
            y_next = -y_sh;
            z_next = DEG180_Q23;
        end else begin
            x_next = x_sh;
            y_next = y_sh;
            z_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign zero_out  = zero_reg;

endmodule
`default_nettype wire

[rtl/cpol_cordic_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpol_cordic_stage
// One vectoring micro-rotation: rotate toward the x axis by atan(2^-STAGE)
// and accumulate the angle, registered with its valid bit.
// ----------------------------------------------------------------------------
module cpol_cordic_stage #(
    parameter int XW    = 27,
    parameter int STAGE = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [XW-1:0]        x_in,
    input  wire logic signed [XW-1:0]        y_in,
    input  wire logic signed [cpol_pkg::Z_W-1:0] z_in,
    input  wire logic                        zero_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [XW-1:0]             x_out,
    output logic signed [XW-1:0]             y_out,
    output logic signed [cpol_pkg::Z_W-1:0]  z_out,
    output logic                             zero_out
);
    import cpol_pkg::*;

    logic                  valid_reg;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic                  zero_reg;
    logic signed [XW-1:0]  xs, ys;
    logic                  advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // A y of exactly zero rotates clockwise
    always_comb begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (y_in[XW-1]) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_Q23[STAGE];
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_Q23[STAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign zero_out  = zero_reg;

endmodule
`default_nettype wire

[rtl/cpol_post.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpol_post
// Two output stages: gain compensation by split multiply, then rounding,
// saturation, angle wrap and the zero-vector override. The second stage is
// the output register.
// ----------------------------------------------------------------------------
module cpol_post #(
    parameter int DATA_WIDTH = 16,
    parameter int ITERATIONS = 16,
    parameter int XW         = 27
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [XW-1:0]            x_in,
    input  wire logic signed [cpol_pkg::Z_W-1:0] z_in,
    input  wire logic                            zero_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [DATA_WIDTH-1:0]                magnitude,
    output logic [cpol_pkg::DIR_W-1:0]           direction
);
    import cpol_pkg::*;

    localparam logic [31:0] INV_GAIN = inv_gain_q32(ITERATIONS);
    localparam int RAW_W   = XW - 1;
    localparam int HI_W    = (RAW_W >= 32) ? RAW_W - 31 : 1;
    localparam int RAW_EXT = 32 + HI_W;
    localparam int PH_W    = HI_W + 32;
    localparam int SUM_W   = PH_W + 1;

    // Stage A: partial products and pre-rounded angle
    logic                 valid_a_reg;
    logic [63:0]          plo_reg, plo_next;
    logic [PH_W-1:0]      phi_reg, phi_next;
    logic [DIR_W:0]       dir_pre_reg, dir_pre_next;
    logic                 zero_a_reg;
    logic [RAW_W-1:0]     raw;
    logic [RAW_EXT-1:0]   raw_ext;
    logic signed [Z_W-1:0] z_pos, z_rnd;
    logic                 advance_a;

    // Stage B: output register
    logic                  valid_b_reg;
    logic [DATA_WIDTH-1:0] mag_reg, mag_next;
    logic [DIR_W-1:0]      dir_reg, dir_next;
    logic [SUM_W-1:0]      sum;
    logic [DIR_W:0]        dir_wrap;
    logic                  advance_b;

    assign advance_b = !valid_b_reg || out_ready;
    assign advance_a = !valid_a_reg || advance_b;
    assign in_ready  = advance_a;

    // Final x is never negative; clamp it anyway
    always_comb begin
        raw      = (x_in > 0) ? x_in[RAW_W-1:0] : '0;
        raw_ext  = RAW_EXT'(raw);
        plo_next = {32'd0, raw_ext[31:0]} * {32'd0, INV_GAIN};
        phi_next = PH_W'(raw_ext[RAW_EXT-1:32]) * PH_W'(INV_GAIN);
        z_pos    = z_in[Z_W-1] ? z_in + DEG360_Q23 : z_in;
        z_rnd    = z_pos + Z_W'(1 << 15);
        dir_pre_next = z_rnd[32:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (advance_a) begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_a && in_valid) begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            dir_pre_reg <= dir_pre_next;
            zero_a_reg  <= zero_in;
        end
    end

    // Round off the guard bits, saturate, wrap a full turn to zero
    always_comb begin
        sum = SUM_W'(phi_reg) + SUM_W'(plo_reg[63:32]) + SUM_W'(1 << (GUARD_BITS - 1));
        if (|sum[SUM_W-1:GUARD_BITS+DATA_WIDTH]) begin
            mag_next = '1;
        end else begin
            mag_next = sum[GUARD_BITS+DATA_WIDTH-1:GUARD_BITS];
        end
        dir_wrap = (dir_pre_reg >= DEG360_Q7) ? dir_pre_reg - DEG360_Q7 : dir_pre_reg;
        dir_next = dir_wrap[DIR_W-1:0];
        if (zero_a_reg) begin
            mag_next = '0;
            dir_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
        end else if (advance_b) begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_b && valid_a_reg) begin
            mag_reg <= mag_next;
            dir_reg <= dir_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign magnitude = mag_reg;
    assign direction = dir_reg;

endmodule
`default_nettype wire

[rtl/cartesian_to_polar_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_polar_core
// Rectangular to polar conversion by a fully pipelined CORDIC in vectoring
// mode: gain-compensated magnitude and direction in Q9.7 degrees, [0, 360).
// ----------------------------------------------------------------------------
//
//  channel   direction  payload (lowest bit first)
//  s_axis    in         tdata: x_in, y_in (DATA_WIDTH bits each, signed)
//  m_axis    out        tdata: magnitude (DATA_WIDTH), direction (16)
//
//  Throughput is one transfer per cycle while the output is not stalled; the
//  registers are one input stage, one register per micro-rotation, a multiply
//  stage for the gain and the output register.
//  Reset clears every stage valid bit; the payload registers are not reset.
//  A stalled output holds its result; each stage keeps advancing while the
//  stage after it is empty, so bubbles collapse and the input accepts a new
//  transfer until the whole pipeline is full.
// ----------------------------------------------------------------------------
module cartesian_to_polar_core #(
    parameter int DATA_WIDTH = 16,
    parameter int ITERATIONS = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // x_in [DATA_WIDTH-1:0], y_in [2*DATA_WIDTH-1:DATA_WIDTH], zero pad above
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // magnitude [DATA_WIDTH-1:0], direction [DATA_WIDTH+15:DATA_WIDTH], zero pad
    output logic [((DATA_WIDTH+cpol_pkg::DIR_W+7)/8)*8-1:0]   m_tdata
);
    import cpol_pkg::*;

    // Guard bits, fold of the left half plane and CORDIC growth
    localparam int XW  = DATA_WIDTH + GUARD_BITS + 3;
    localparam int M_W = ((DATA_WIDTH + DIR_W + 7) / 8) * 8;

    logic signed [DATA_WIDTH-1:0] x_in, y_in;

    // Stage k feeds micro-rotation k; the last entry feeds the output stages
    logic                  vld  [0:ITERATIONS];
    logic                  rdy  [0:ITERATIONS];
    logic signed [XW-1:0]  xp   [0:ITERATIONS];
    logic signed [XW-1:0]  yp   [0:ITERATIONS];
    logic signed [Z_W-1:0] zp   [0:ITERATIONS];
    logic                  zrp  [0:ITERATIONS];

    logic [DATA_WIDTH-1:0] magnitude;
    logic [DIR_W-1:0]      direction;

    assign x_in = s_tdata[DATA_WIDTH-1:0];
    assign y_in = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    cpol_prerot #(
        .DATA_WIDTH (DATA_WIDTH),
        .XW         (XW)
    ) u_prerot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_in      (x_in),
        .y_in      (y_in),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .x_out     (xp[0]),
        .y_out     (yp[0]),
        .z_out     (zp[0]),
        .zero_out  (zrp[0])
    );

    // One registered micro-rotation per iteration
    for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
        cpol_cordic_stage #(
            .XW    (XW),
            .STAGE (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .x_in      (xp[k]),
            .y_in      (yp[k]),
            .z_in      (zp[k]),
            .zero_in   (zrp[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .x_out     (xp[k+1]),
            .y_out     (yp[k+1]),
            .z_out     (zp[k+1]),
            .zero_out  (zrp[k+1])
        );
    end

    // Gain compensation and output register; the final y is not needed
    cpol_post #(
        .DATA_WIDTH (DATA_WIDTH),
        .ITERATIONS (ITERATIONS),
        .XW         (XW)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[ITERATIONS]),
        .in_ready  (rdy[ITERATIONS]),
        .x_in      (xp[ITERATIONS]),
        .z_in      (zp[ITERATIONS]),
        .zero_in   (zrp[ITERATIONS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .magnitude (magnitude),
        .direction (direction)
    );

    assign m_tdata = M_W'({direction, magnitude});

endmodule
`default_nettype wire

[test/tb_cartesian_to_polar_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_core
// Self-checking bench for the rectangular to polar CORDIC core. A directed
// walk over axes, diagonals and full-scale corners is followed by random
// vectors. Every transfer is predicted bit for bit by a local CORDIC model
// and compared in order against the result stream, under random idling on
// both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_core;

    localparam int DATA_WIDTH  = 16;
    localparam int ITERATIONS  = 16;
    localparam int S_W         = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_W         = ((DATA_WIDTH + cpol_pkg::DIR_W + 7) / 8) * 8;
    localparam int LATENCY     = ITERATIONS + 3;
    localparam int GUARD       = 8;
    localparam int IDLE_PCT    = 31;
    localparam int HOLD_CYCLES = 150;
    localparam longint DEG180  = 64'sd1509949440;
    localparam longint DEG360  = 64'sd3019898880;
    localparam longint unsigned FULL_TURN_Q7 = 64'd46080;
    localparam longint unsigned MAG_MAX = (64'd1 << DATA_WIDTH) - 1;
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    // atan(2^-i) in 2^-23 degree units
    localparam longint ATAN_STEP [0:ITERATIONS-1] = '{
        377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
        7509261, 3754860, 1877459, 938733, 469367, 234683, 117342, 58671,
        29335, 14668
    };

    typedef struct packed {
        logic [15:0] dir;
        logic [15:0] mag;
    } polar_t;

    // one directed vector; fixed rows carry their result typed in
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        bit          fixed;
        logic [15:0] mag;
        logic [15:0] dir;
    } probe_t;

    localparam int N_PROBES = 24;
    localparam probe_t PROBES [0:N_PROBES-1] = '{
        '{16'h0000, 16'h0000, 1'b1, 16'd0, 16'd0},
        '{16'h0001, 16'h0000, 1'b0, 16'd0, 16'd0},
        '{16'h0000, 16'h0001, 1'b0, 16'd0, 16'd0},
        '{16'hFFFF, 16'h0000, 1'b0, 16'd0, 16'd0},
        '{16'h0000, 16'hFFFF, 1'b0, 16'd0, 16'd0},
        '{16'h7FFF, 16'h0000, 1'b0, 16'd0, 16'd0},
        '{16'h8000, 16'h0000, 1'b0, 16'd0, 16'd0},
        '{16'h0000, 16'h7FFF, 1'b0, 16'd0, 16'd0},
        '{16'h0000, 16'h8000, 1'b0, 16'd0, 16'd0},
        '{16'h7FFF, 16'h7FFF, 1'b0, 16'd0, 16'd0},
        '{16'h8000, 16'h8000, 1'b0, 16'd0, 16'd0},
        '{16'h7FFF, 16'h8000, 1'b0, 16'd0, 16'd0},
        '{16'h8000, 16'h7FFF, 1'b0, 16'd0, 16'd0},
        '{16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0},
        '{16'h0001, 16'h0001, 1'b0, 16'd0, 16'd0},
        '{16'hFFFF, 16'h0001, 1'b0, 16'd0, 16'd0},
        '{16'h0001, 16'hFFFF, 1'b0, 16'd0, 16'd0},
        '{16'd1000, 16'h0000, 1'b0, 16'd0, 16'd0},
        '{-16'sd1000, 16'h0000, 1'b0, 16'd0, 16'd0},
        '{16'd3, 16'd4, 1'b0, 16'd0, 16'd0},
        '{-16'sd3, -16'sd4, 1'b0, 16'd0, 16'd0},
        '{16'd100, -16'sd1, 1'b0, 16'd0, 16'd0},
        '{-16'sd100, 16'd1, 1'b0, 16'd0, 16'd0},
        '{16'h0000, 16'h0000, 1'b1, 16'd0, 16'd0}
    };

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    polar_t pending_polar [$];
    longint unsigned gain_recip_q32;
    int  mismatches = 0;
    bit  no_gaps = 1'b0;
    bit  hold_req = 1'b0;

    cartesian_to_polar_core #(
        .DATA_WIDTH (DATA_WIDTH),
        .ITERATIONS (ITERATIONS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("cartesian_to_polar_core: mismatch");
        $finish;
    end

    // 2^62 / G rounded to nearest, G = sqrt of the accumulated squared gain in Q30
    function automatic longint unsigned cordic_gain_recip(input int iters);
        longint unsigned g2;
        longint unsigned v;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        g2 = 64'd1 << 30;
        for (int i = 0; i < iters; i++) begin
            g2 = g2 + (g2 >> (2 * i));
        end
        v  = g2 << 30;
        lo = 0;
        hi = 64'hFFFF_FFFF;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (lo == 0) begin
            lo = 1;
        end
        return ((64'd1 << 62) + (lo >> 1)) / lo;
    endfunction

    function automatic polar_t polar_of(input logic signed [15:0] xi,
                                        input logic signed [15:0] yi);
        longint xa;
        longint ya;
        longint za;
        longint xs;
        longint ys;
        longint unsigned raw;
        longint unsigned mag;
        longint unsigned dir;
        polar_t res;
        res = '0;
        if (xi == 0 && yi == 0) begin
            return res;
        end
        xa = xi;
        ya = yi;
        xa = xa * (64'sd1 <<< GUARD);
        ya = ya * (64'sd1 <<< GUARD);
        za = 0;
        // fold the left half plane onto the right one
        if (xa < 0) begin
            xa = -xa;
            ya = -ya;
            za = DEG180;
        end
        for (int i = 0; i < ITERATIONS; i++) begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya < 0) begin
                xa = xa - ys;
                ya = ya + xs;
                za = za - ATAN_STEP[i];
            end else begin
                xa = xa + ys;
                ya = ya - xs;
                za = za + ATAN_STEP[i];
            end
        end
        raw = (xa > 0) ? xa : 0;
        mag = (((raw * gain_recip_q32) >> 32) + (64'd1 << (GUARD - 1))) >> GUARD;
        if (mag > MAG_MAX) begin
            mag = MAG_MAX;
        end
        if (za < 0) begin
            za = za + DEG360;
        end
        dir = (za + 64'sd32768) >>> 16;
        while (dir >= FULL_TURN_Q7) begin
            dir = dir - FULL_TURN_Q7;
        end
        res.mag = mag[15:0];
        res.dir = dir[15:0];
        return res;
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(5))
            0: begin
                return 16'h8000;
            end
            1: begin
                return 16'h8001;
            end
            2: begin
                return 16'hFFFF;
            end
            3: begin
                return 16'h0000;
            end
            4: begin
                return 16'h0001;
            end
            default: begin
                return 16'h7FFF;
            end
        endcase
    endfunction

    // mostly full-range vectors, with small ones, axes, diagonals and corners
    function automatic logic [31:0] pick_vector();
        logic [15:0] x;
        logic [15:0] y;
        int kind;
        kind = $urandom_range(99);
        x = 16'($urandom);
        y = 16'($urandom);
        if (kind < 15) begin
            x = 16'($urandom_range(128) - 64);
            y = 16'($urandom_range(128) - 64);
        end else if (kind < 27) begin
            case ($urandom_range(3))
                0: begin
                    y = 16'h0000;
                end
                1: begin
                    x = 16'h0000;
                end
                2: begin
                    y = x;
                end
                default: begin
                    y = -x;
                end
            endcase
        end else if (kind < 37) begin
            x = corner_value();
            y = corner_value();
        end
        return {y, x};
    endfunction

    task automatic note_mismatch(input string what, input polar_t want,
                                 input polar_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: magnitude exp %0d got %0d, direction exp %0d got %0d",
                     $time, what, want.mag, got.mag, want.dir, got.dir);
        end
    endtask

    // offer one vector, hold it until the transfer, then log its result
    task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                               input bit fixed, input polar_t fixed_res);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
        pending_polar.insert(pending_polar.size(), fixed ? fixed_res : polar_of(x, y));
    endtask

    task automatic send_random(input int count);
        logic [31:0] v;
        for (int n = 0; n < count; n++) begin
            v = pick_vector();
            send_vector(v[15:0], v[31:16], 1'b0, '0);
        end
    endtask

    // compare each result transfer against the oldest prediction
    always @(posedge aclk) begin
        polar_t got;
        polar_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.mag = m_tdata[DATA_WIDTH-1:0];
            got.dir = m_tdata[DATA_WIDTH+15:DATA_WIDTH];
            if (pending_polar.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_polar.pop_front();
                if (got.mag !== want.mag || got.dir !== want.dir) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // result side: random backpressure, a steady stretch, one long hold-off
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (no_gaps) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        probe_t p;
        gain_recip_q32 = cordic_gain_recip(ITERATIONS);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_PROBES; r++) begin
            p = PROBES[r];
            send_vector(p.x, p.y, p.fixed, '{dir: p.dir, mag: p.mag});
        end

        send_random(350);

        no_gaps = 1'b1;
        send_random(200);

        // stall the output long enough to fill the pipe and back up the input
        hold_req = 1'b1;
        send_random(80);
        no_gaps = 1'b0;

        // pause the input until the pipe has drained
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_polar.size() != 0);

        send_random(300);
        s_tvalid <= 1'b0;

        while (pending_polar.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * LATENCY) @(posedge aclk);

        if (mismatches == 0 && pending_polar.size() == 0) begin
            $display("cartesian_to_polar_core: match");
        end else begin
            $display("cartesian_to_polar_core: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/cpol_pkg.sv
rtl/cpol_prerot.sv
rtl/cpol_cordic_stage.sv
rtl/cpol_post.sv
rtl/cartesian_to_polar_core.sv
test/tb_cartesian_to_polar_core.sv
